>>> rtl/core/pcl_pkg.sv
// Shared widths, operation codes and controller/datapath link types for the labeller.
package pcl_pkg;

    localparam int GRID_SIZE_DEF = 64;

    localparam int OP_W    = 2;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int LABEL_W = 13;
    localparam int STEP_W  = 16;

    localparam logic [STEP_W-1:0] MAX_STEPS_RST = 16'd1024;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef logic [LABEL_W-1:0] label_t;

    // controller to datapath
    typedef struct packed {
        logic idle;
        logic sweep_start;
        logic flip;
        logic perc_start;
        logic resp_push;
        logic perc_flag;
        logic conv_flag;
    } pcl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic run_acc;
        logic p_free;
        logic sweep_done;
        logic changed;
        logic perc_done;
        logic hit;
    } pcl_stat_t;

endpackage

>>> rtl/core/pcl_if.sv
// Valid/ready channel interfaces for request and response words.
interface pcl_in_if;
    logic                         valid;
    logic                         ready;
    logic [pcl_pkg::OP_W-1:0]     operation;
    logic [pcl_pkg::ROW_W-1:0]    row;
    logic [pcl_pkg::COL_W-1:0]    col;
    logic [pcl_pkg::LABEL_W-1:0]  label;

    modport source (output valid, output operation, output row, output col, output label,
                    input ready);
    modport sink   (input valid, input operation, input row, input col, input label,
                    output ready);
endinterface

interface pcl_out_if;
    logic                         valid;
    logic                         ready;
    logic [pcl_pkg::LABEL_W-1:0]  read_label;
    logic                         percolates;
    logic                         converged;

    modport source (output valid, output read_label, output percolates, output converged,
                    input ready);
    modport sink   (input valid, input read_label, input percolates, input converged,
                    output ready);
endinterface

>>> rtl/core/pcl_ctrl.sv
// Run sequencer: sweep count, convergence and percolation flags, limit register.
module pcl_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pcl_pkg::STEP_W-1:0]   cfg_data,
    input  pcl_pkg::pcl_stat_t           stat,
    output pcl_pkg::pcl_cmd_t            cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CHECK     = 3'd1;
    localparam logic [2:0] ST_SWEEP     = 3'd2;
    localparam logic [2:0] ST_SWEEP_END = 3'd3;
    localparam logic [2:0] ST_PERC      = 3'd4;
    localparam logic [2:0] ST_RESP      = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [pcl_pkg::STEP_W-1:0]  max_steps_reg;
    logic [pcl_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        perc_flag_reg, perc_flag_next;
    logic                        conv_flag_reg, conv_flag_next;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        perc_flag_next  = perc_flag_reg;
        conv_flag_next  = conv_flag_reg;
        cmd             = '0;
        cmd.idle        = (state_reg == ST_IDLE);
        cmd.perc_flag   = perc_flag_reg;
        cmd.conv_flag   = conv_flag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.run_acc)
                begin
                    step_next  = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (step_reg == max_steps_reg)
                begin
                    conv_flag_next = 1'b0;
                    cmd.perc_start = 1'b1;
                    state_next     = ST_PERC;
                end
                else
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (stat.sweep_done)
                begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END:
            begin
                cmd.flip = 1'b1;
                if (!stat.changed)
                begin
                    conv_flag_next = 1'b1;
                    cmd.perc_start = 1'b1;
                    state_next     = ST_PERC;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_PERC:
            begin
                if (stat.perc_done)
                begin
                    perc_flag_next = stat.hit;
                    state_next     = ST_RESP;
                end
            end
            ST_RESP:
            begin
                cmd.resp_push = stat.p_free;
                if (stat.p_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state, flags and limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            perc_flag_reg <= 1'b0;
            conv_flag_reg <= 1'b0;
            max_steps_reg <= pcl_pkg::MAX_STEPS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            perc_flag_reg <= perc_flag_next;
            conv_flag_reg <= conv_flag_next;
            if (cfg_we)
            begin
                max_steps_reg <= cfg_data;
            end
        end
    end

endmodule

>>> rtl/core/pcl_datapath.sv
// Grid memory, sweep line buffer, percolation scan and response stages.
module pcl_datapath #(
    parameter int GRID_SIZE = pcl_pkg::GRID_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pcl_in_if.sink               req,
    pcl_out_if.source            rsp,
    input  pcl_pkg::pcl_cmd_t    cmd,
    output pcl_pkg::pcl_stat_t   stat
);

    localparam int IDX_W   = $clog2(GRID_SIZE);
    localparam int K_W     = $clog2(GRID_SIZE + 2);
    localparam int J_W     = $clog2(GRID_SIZE + 1);
    localparam int ADDR_W  = 2 * IDX_W + 1;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int TAPS    = 2 * GRID_SIZE + 1;
    localparam int ROW_CNT = 2 ** pcl_pkg::ROW_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);
    localparam logic [K_W-1:0]   K_LAST   = K_W'(GRID_SIZE + 1);
    localparam logic [K_W-1:0]   K_FIRST  = K_W'(2);
    localparam logic [J_W-1:0]   J_LAST   = J_W'(GRID_SIZE);
    localparam logic [8:0]       GRID_EXT = 9'(GRID_SIZE);

    // request decode
    logic [IDX_W-1:0]     row_wrap [ROW_CNT];
    logic [IDX_W-1:0]     acc_row, acc_col;
    logic                 col_ok, acc, p_adv, p_free;

    // memory ports
    pcl_pkg::label_t      grid_mem [DEPTH];
    pcl_pkg::label_t      rd_data_reg;
    logic                 rd_en, wr_en;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    pcl_pkg::label_t      wr_data;
    logic                 bank_reg;

    // sweep pipeline
    logic                 sw_issue_reg;
    logic [K_W-1:0]       sw_k_reg, sw_kb_reg, sw_kc_reg;
    logic [IDX_W-1:0]     sw_c_reg, sw_cb_reg, sw_cc_reg;
    logic                 sw_vb_reg, sw_vc_reg, sw_changed_reg;
    logic [IDX_W-1:0]     sw_row_rd;
    pcl_pkg::label_t      tap_reg [TAPS];
    pcl_pkg::label_t      cur, up, dn, lf, rt, m1, m2, m3, best;
    logic                 sw_wr, changed_now;

    // percolation scan
    logic                 pc_issue_reg, pc_vb_reg, pc_anchor_b_reg, pc_last_b_reg;
    logic [IDX_W-1:0]     pc_i_reg;
    logic [J_W-1:0]       pc_j_reg;
    logic [ADDR_W-1:0]    pc_addr;
    pcl_pkg::label_t      anchor_reg;
    logic                 pc_hit_reg, hit_now;

    // response stages
    logic                 p_valid_reg, p_read_reg, p_perc_reg, p_conv_reg;
    logic                 rsp_valid_reg, rsp_perc_reg, rsp_conv_reg;
    pcl_pkg::label_t      rsp_label_reg;

    // reduce row modulo grid size through a constant table
    for (genvar g = 0; g < ROW_CNT; g++)
    begin : g_row_wrap
        assign row_wrap[g] = IDX_W'(g % GRID_SIZE);
    end

    assign acc_row = row_wrap[req.row];
    assign acc_col = IDX_W'(req.col);
    assign col_ok  = 9'(req.col) < GRID_EXT;

    // handshake
    assign p_adv     = !rsp_valid_reg || rsp.ready;
    assign p_free    = !p_valid_reg || p_adv;
    assign req.ready = cmd.idle && p_free;
    assign acc       = req.valid && req.ready;

    // sweep read row: last row first, then every row, then row zero again
    always_comb
    begin
        if (sw_k_reg == '0)
        begin
            sw_row_rd = LAST_IDX;
        end
        else if (sw_k_reg == K_LAST)
        begin
            sw_row_rd = '0;
        end
        else
        begin
            sw_row_rd = IDX_W'(sw_k_reg - 1'b1);
        end
    end

    // percolation read: anchor in last column, then the whole first column
    assign pc_addr = (pc_j_reg == '0) ? {bank_reg, pc_i_reg, LAST_IDX}
                                      : {bank_reg, IDX_W'(pc_j_reg - 1'b1), {IDX_W{1'b0}}};

    // select read port
    always_comb
    begin
        rd_en = sw_issue_reg || pc_issue_reg || acc;
        if (sw_issue_reg)
        begin
            rd_addr = {bank_reg, sw_row_rd, sw_c_reg};
        end
        else if (pc_issue_reg)
        begin
            rd_addr = pc_addr;
        end
        else
        begin
            rd_addr = {bank_reg, acc_row, acc_col};
        end
    end

    // relax centre cell from the line buffer taps
    assign cur  = tap_reg[GRID_SIZE];
    assign up   = tap_reg[2 * GRID_SIZE];
    assign dn   = tap_reg[0];
    assign lf   = (sw_cc_reg == '0) ? '0 : tap_reg[GRID_SIZE + 1];
    assign rt   = (sw_cc_reg == LAST_IDX) ? '0 : tap_reg[GRID_SIZE - 1];
    assign m1   = (up > dn) ? up : dn;
    assign m2   = (lf > rt) ? lf : rt;
    assign m3   = (m1 > m2) ? m1 : m2;
    assign best = (cur == '0) ? '0 : ((m3 > cur) ? m3 : cur);

    assign sw_wr       = sw_vc_reg && (sw_kc_reg >= K_FIRST);
    assign changed_now = sw_wr && (best != cur);

    // select write port
    always_comb
    begin
        if (sw_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = {~bank_reg, IDX_W'(sw_kc_reg - K_FIRST), sw_cc_reg};
            wr_data = best;
        end
        else
        begin
            wr_en   = acc && (req.operation == pcl_pkg::OP_WRITE) && col_ok;
            wr_addr = {bank_reg, acc_row, acc_col};
            wr_data = req.label;
        end
    end

    // grid memory, two banks
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // shift line buffer
    always_ff @(posedge clk)
    begin
        if (sw_vb_reg)
        begin
            tap_reg[0] <= rd_data_reg;
            for (int t = 1; t < TAPS; t++)
            begin
                tap_reg[t] <= tap_reg[t-1];
            end
        end
    end

    assign hit_now = pc_vb_reg && !pc_anchor_b_reg && (anchor_reg != '0)
                     && (rd_data_reg == anchor_reg);

    // advance sweep and scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg        <= 1'b0;
            sw_issue_reg    <= 1'b0;
            sw_k_reg        <= '0;
            sw_c_reg        <= '0;
            sw_vb_reg       <= 1'b0;
            sw_vc_reg       <= 1'b0;
            sw_changed_reg  <= 1'b0;
            pc_issue_reg    <= 1'b0;
            pc_i_reg        <= '0;
            pc_j_reg        <= '0;
            pc_vb_reg       <= 1'b0;
            pc_hit_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.flip)
            begin
                bank_reg <= ~bank_reg;
            end
            if (cmd.sweep_start)
            begin
                sw_issue_reg   <= 1'b1;
                sw_k_reg       <= '0;
                sw_c_reg       <= '0;
                sw_changed_reg <= 1'b0;
            end
            else
            begin
                if (sw_issue_reg)
                begin
                    if (sw_c_reg == LAST_IDX)
                    begin
                        sw_c_reg <= '0;
                        sw_k_reg <= sw_k_reg + 1'b1;
                        if (sw_k_reg == K_LAST)
                        begin
                            sw_issue_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        sw_c_reg <= sw_c_reg + 1'b1;
                    end
                end
                if (changed_now)
                begin
                    sw_changed_reg <= 1'b1;
                end
            end
            sw_vb_reg <= sw_issue_reg;
            sw_vc_reg <= sw_vb_reg;

            if (cmd.perc_start)
            begin
                pc_issue_reg <= 1'b1;
                pc_i_reg     <= '0;
                pc_j_reg     <= '0;
                pc_hit_reg   <= 1'b0;
            end
            else
            begin
                if (pc_issue_reg)
                begin
                    if (pc_j_reg == J_LAST)
                    begin
                        pc_j_reg <= '0;
                        if (pc_i_reg == LAST_IDX)
                        begin
                            pc_issue_reg <= 1'b0;
                        end
                        else
                        begin
                            pc_i_reg <= pc_i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pc_j_reg <= pc_j_reg + 1'b1;
                    end
                end
                if (hit_now)
                begin
                    pc_hit_reg <= 1'b1;
                end
            end
            pc_vb_reg <= pc_issue_reg;
        end
    end

    // carry tags alongside the memory read
    always_ff @(posedge clk)
    begin
        sw_kb_reg       <= sw_k_reg;
        sw_cb_reg       <= sw_c_reg;
        sw_kc_reg       <= sw_kb_reg;
        sw_cc_reg       <= sw_cb_reg;
        pc_anchor_b_reg <= (pc_j_reg == '0);
        pc_last_b_reg   <= (pc_i_reg == LAST_IDX) && (pc_j_reg == J_LAST);
        if (pc_vb_reg && pc_anchor_b_reg)
        begin
            anchor_reg <= rd_data_reg;
        end
    end

    // response valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if ((acc && (req.operation != pcl_pkg::OP_RUN)) || cmd.resp_push)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_adv)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv)
            begin
                rsp_valid_reg <= p_valid_reg;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p_read_reg <= (req.operation == pcl_pkg::OP_READ) && col_ok;
            p_perc_reg <= cmd.perc_flag;
            p_conv_reg <= cmd.conv_flag;
        end
        else if (cmd.resp_push)
        begin
            p_read_reg <= 1'b0;
            p_perc_reg <= cmd.perc_flag;
            p_conv_reg <= cmd.conv_flag;
        end
        if (p_adv && p_valid_reg)
        begin
            rsp_label_reg <= p_read_reg ? rd_data_reg : '0;
            rsp_perc_reg  <= p_perc_reg;
            rsp_conv_reg  <= p_conv_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_label = rsp_label_reg;
    assign rsp.percolates = rsp_perc_reg;
    assign rsp.converged  = rsp_conv_reg;

    // status to controller
    assign stat.run_acc    = acc && (req.operation == pcl_pkg::OP_RUN);
    assign stat.p_free     = p_free;
    assign stat.sweep_done = sw_vc_reg && (sw_kc_reg == K_LAST) && (sw_cc_reg == LAST_IDX);
    assign stat.changed    = sw_changed_reg;
    assign stat.perc_done  = pc_vb_reg && pc_last_b_reg;
    assign stat.hit        = pc_hit_reg || hit_now;

endmodule

>>> rtl/core/percolation_cluster_labeler.sv
// Top level of the percolation cluster labeller: controller plus datapath.
//
// Request channel req carries one word per operation: write a cell, run the
// relaxation and percolation test, or read a cell (operation 3 is a no-op).
// Every request gives exactly one word on response channel rsp, in order. The
// user must load the sweep limit via cfg_we / cfg_data only while the block
// is idle; the block itself does not enforce this.
//
// Writes and reads are taken one per cycle while rsp is not stalled; each
// response passes through the read register and then the output register. A
// run holds req.ready low until its response is queued. Each sweep streams the
// grid once through a single-port read of the grid memory into a two-row line
// buffer, and the percolation test streams the first column once for each
// last-column cell.
//
// Reset clears the flags and all handshake state and sets the sweep limit to
// 1024; grid contents are undefined until written. A stalled rsp holds its
// word, and req.ready drops once the read register is also full.
module percolation_cluster_labeler #(
    parameter int GRID_SIZE = pcl_pkg::GRID_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    pcl_in_if.sink                       req,
    pcl_out_if.source                    rsp,
    input  logic                         cfg_we,
    input  logic [pcl_pkg::STEP_W-1:0]   cfg_data
);

    pcl_pkg::pcl_cmd_t   cmd;
    pcl_pkg::pcl_stat_t  stat;

    // sequence runs
    pcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold the grid and move words
    pcl_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

>>> rtl/core/pcl_checker.sv
// Port-level checks of the labeller, bound to the top level.
module pcl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [pcl_pkg::OP_W-1:0]      req_operation,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pcl_pkg::LABEL_W-1:0]   rsp_read_label,
    input logic                          rsp_percolates,
    input logic                          rsp_converged
);

    // hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_label)
            && $stable(rsp_percolates) && $stable(rsp_converged))
        else $error("stalled response word changed");

    // drop ready once a run is taken
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation == pcl_pkg::OP_RUN) |=> !req_ready)
        else $error("request taken while a run is in progress");

    // a cell access is followed by a valid response word
    a_access_answer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_operation != pcl_pkg::OP_RUN) |-> ##2 rsp_valid)
        else $error("no response word after cell access");

endmodule

bind percolation_cluster_labeler pcl_checker u_pcl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_operation  (req.operation),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_label (rsp.read_label),
    .rsp_percolates (rsp.percolates),
    .rsp_converged  (rsp.converged)
);
